@@ hdl/mbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types, character codes and the byte classifier for the mail body
// canonicalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbc_pkg;

    // Width of the held CRLF counter (saturating)
    localparam int NEWLINE_COUNT_BITS = 16;

    // Decoupling queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Byte class decided in the front
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_CR    = 2'd1,
        CLS_LF    = 2'd2,
        CLS_WSP   = 2'd3
    } byte_class_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic        byte_present;
        logic [7:0]  body_byte;
        logic        end_of_body;
        byte_class_t byte_class;
    } item_t;

    // One result item
    typedef struct packed {
        logic [NEWLINE_COUNT_BITS-1:0] newline_count;
        logic                          space_before;
        logic                          cr_before;
        logic                          out_valid;
        logic [7:0]                    out_byte;
        logic                          final_newline;
        logic                          last_result;
    } result_t;

    // Map a raw byte to its class
    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t cls;
        cls = CLS_OTHER;
        if (b == CH_CR)
            cls = CLS_CR;
        else if (b == CH_LF)
            cls = CLS_LF;
        else if (b == CH_SP || b == CH_TAB)
            cls = CLS_WSP;
        return cls;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mail_body_canonicalizer_unit.sv @@
// ----------------------------------------------------------------------------
// mail_body_canonicalizer_unit
// DKIM body canonicalization, simple and relaxed, over a byte stream.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | item_valid/item_ready| byte_present, body_byte, end_of_body
//  result   | res_valid/res_ready  | newline_count, space_before, cr_before,
//           |                      | out_valid, out_byte, final_newline,
//           |                      | last_result
//  config   | cfg_valid/cfg_ready  | relaxed_mode
//
//  One item per cycle sustained while the result channel is not stalled;
//  an accepted item passes the front register, then a queue entry, then
//  the result register.
//  The back engine updates its state once per item; that loop sets the
//  rate.
//  Reset clears all body state and selects simple mode.
//  A stalled result holds the back; the four-entry queue and the front
//  register keep absorbing input until full.
// ----------------------------------------------------------------------------
`default_nettype none

module mail_body_canonicalizer_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic                                   relaxed_mode,
    // input items
    input  wire logic                                   item_valid,
    output logic                                        item_ready,
    input  wire logic                                   byte_present,
    input  wire logic [7:0]                             body_byte,
    input  wire logic                                   end_of_body,
    // result items
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0]      newline_count,
    output logic                                        space_before,
    output logic                                        cr_before,
    output logic                                        out_valid,
    output logic [7:0]                                  out_byte,
    output logic                                        final_newline,
    output logic                                        last_result
);

    logic             relaxed_reg;
    logic             push_valid;
    logic             push_ready;
    mbc_pkg::item_t   push_item;
    logic             pop_valid;
    logic             pop_ready;
    mbc_pkg::item_t   pop_item;
    mbc_pkg::result_t res_data;

    // mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            relaxed_reg <= 1'b0;
        else if (cfg_valid)
            relaxed_reg <= relaxed_mode;
    end

    mbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .byte_present (byte_present),
        .body_byte    (body_byte),
        .end_of_body  (end_of_body),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    mbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .relaxed_mode (relaxed_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_data     (res_data)
    );

    // result fields
    assign newline_count = res_data.newline_count;
    assign space_before  = res_data.space_before;
    assign cr_before     = res_data.cr_before;
    assign out_valid     = res_data.out_valid;
    assign out_byte      = res_data.out_byte;
    assign final_newline = res_data.final_newline;
    assign last_result   = res_data.last_result;

endmodule

`default_nettype wire

@@ hdl/mbc_front.sv @@
// ----------------------------------------------------------------------------
// mbc_front
// Input stage: takes body items, classifies the byte and hands the
// classified item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input channel
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire logic           byte_present,
    input  wire logic [7:0]     body_byte,
    input  wire logic           end_of_body,
    // toward queue
    output logic                push_valid,
    input  wire logic           push_ready,
    output mbc_pkg::item_t      push_item
);

    logic           valid_reg;
    logic           valid_next;
    mbc_pkg::item_t item_reg;

    // stage is free when empty or draining this cycle
    assign item_ready = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
            valid_next = item_valid;
        else if (push_ready)
            valid_next = 1'b0;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture with classification
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.byte_present <= byte_present;
            item_reg.body_byte    <= body_byte;
            item_reg.end_of_body  <= end_of_body;
            item_reg.byte_class   <= mbc_pkg::classify(body_byte);
        end
    end

endmodule

`default_nettype wire

@@ hdl/mbc_queue.sv @@
// ----------------------------------------------------------------------------
// mbc_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mbc_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output mbc_pkg::item_t      pop_item
);

    mbc_pkg::item_t                    entry_reg [mbc_pkg::Q_DEPTH];
    logic [mbc_pkg::Q_PTR_BITS-1:0]    wr_ptr_reg;
    logic [mbc_pkg::Q_PTR_BITS-1:0]    rd_ptr_reg;
    logic [mbc_pkg::Q_CNT_BITS-1:0]    count_reg;
    logic [mbc_pkg::Q_CNT_BITS-1:0]    count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != mbc_pkg::Q_CNT_BITS'(mbc_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

@@ hdl/mbc_back.sv @@
// ----------------------------------------------------------------------------
// mbc_back
// Canonicalization engine: holds CRLF count, pending space, pending CR and
// content flag, and builds one result into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           relaxed_mode,
    // from queue
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire mbc_pkg::item_t pop_item,
    // result channel
    output logic                res_valid,
    input  wire logic           res_ready,
    output mbc_pkg::result_t    res_data
);

    localparam logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] HELD_MAX = '1;

    logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] held_reg;
    logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] held_next;
    logic                                   space_reg;
    logic                                   space_next;
    logic                                   cr_reg;
    logic                                   cr_next;
    logic                                   seen_reg;
    logic                                   seen_next;
    logic                                   res_valid_reg;
    logic                                   res_valid_next;
    mbc_pkg::result_t                       res_reg;
    mbc_pkg::result_t                       res_next;
    logic                                   emit;
    logic                                   fire;

    assign fire      = pop_valid && (!res_valid_reg || res_ready);
    assign pop_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // per-item state update and result build
    always_comb
    begin
        held_next  = held_reg;
        space_next = space_reg;
        cr_next    = cr_reg;
        seen_next  = seen_reg;
        res_next   = '0;
        emit       = 1'b0;

        if (pop_item.byte_present)
        begin
            priority if (cr_next && pop_item.byte_class == mbc_pkg::CLS_LF)
            begin
                // CRLF completes: count it, drop pending space
                if (held_next != HELD_MAX)
                    held_next = held_next + 1'b1;
                cr_next    = 1'b0;
                space_next = 1'b0;
            end
            else if (relaxed_mode && pop_item.byte_class == mbc_pkg::CLS_WSP)
            begin
                if (cr_next)
                begin
                    res_next.newline_count = held_next;
                    res_next.space_before  = space_next;
                    res_next.cr_before     = 1'b1;
                    held_next  = '0;
                    seen_next  = 1'b1;
                    cr_next    = 1'b0;
                    emit       = 1'b1;
                end
                space_next = 1'b1;
            end
            else if (pop_item.byte_class == mbc_pkg::CLS_CR)
            begin
                // a second CR releases the first as a lone CR
                if (cr_next)
                begin
                    res_next.newline_count = held_next;
                    res_next.space_before  = space_next;
                    res_next.cr_before     = 1'b1;
                    held_next  = '0;
                    space_next = 1'b0;
                    seen_next  = 1'b1;
                    emit       = 1'b1;
                end
                cr_next = 1'b1;
            end
            else
            begin
                // content byte
                res_next.newline_count = held_next;
                res_next.space_before  = space_next;
                res_next.cr_before     = cr_next;
                res_next.out_valid     = 1'b1;
                res_next.out_byte      = pop_item.body_byte;
                held_next  = '0;
                space_next = 1'b0;
                seen_next  = 1'b1;
                cr_next    = 1'b0;
                emit       = 1'b1;
            end
        end

        if (pop_item.end_of_body)
        begin
            // a CR still held goes out as the content byte
            if (cr_next)
            begin
                res_next.newline_count = res_next.newline_count | held_next;
                res_next.space_before  = res_next.space_before | space_next;
                res_next.out_valid     = 1'b1;
                res_next.out_byte      = mbc_pkg::CH_CR;
                seen_next = 1'b1;
            end
            res_next.final_newline = relaxed_mode ? seen_next : 1'b1;
            res_next.last_result   = 1'b1;
            emit       = 1'b1;
            held_next  = '0;
            space_next = 1'b0;
            cr_next    = 1'b0;
            seen_next  = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = emit;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    // body state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            space_reg     <= 1'b0;
            cr_reg        <= 1'b0;
            seen_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                held_reg  <= held_next;
                space_reg <= space_next;
                cr_reg    <= cr_next;
                seen_reg  <= seen_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ hdl/mbc_checker.sv @@
// ----------------------------------------------------------------------------
// mbc_checker
// Port-level checks on the result stream of the canonicalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              res_valid,
    input  wire logic                              res_ready,
    input  wire logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] newline_count,
    input  wire logic                              space_before,
    input  wire logic                              cr_before,
    input  wire logic                              out_valid,
    input  wire logic [7:0]                        out_byte,
    input  wire logic                              final_newline,
    input  wire logic                              last_result
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({newline_count, space_before, cr_before,
                                             out_valid, out_byte, final_newline,
                                             last_result}))
        else $error("result payload changed while stalled");

    // no content byte means a zero byte field
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == 8'h00)
        else $error("out_byte set without out_valid");

    // a mid-body result always carries a CR or a byte
    a_mid_content: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last_result |-> (cr_before || out_valid))
        else $error("empty mid-body result");

    // the closing CRLF only on the last result
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && final_newline |-> last_result)
        else $error("final newline on non-last result");

endmodule

bind mail_body_canonicalizer_unit mbc_checker u_mbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .newline_count (newline_count),
    .space_before  (space_before),
    .cr_before     (cr_before),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .final_newline (final_newline),
    .last_result   (last_result)
);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DKIM body canonicalizer. A short table of
// directed items (empty bodies, byte extremes, held CR and CRLF, whitespace
// runs) comes first. Phases of random body streams follow, with the mode
// switched between phases, and a closing run that releases a CRLF backlog.
// Every accepted item goes through a local canonicalization model. Results
// are compared in order against that model, or against the value typed into
// the table where it is obvious. Both handshakes idle in random bursts.
// One long result stall fills the block and stalls its input.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_MAX     = 10;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 175;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_WAIT     = 16;
    localparam int PRESSURE_PHASE = 2;
    localparam int TAIL_LINES     = 4;

    // One directed item with its optional typed-in result
    typedef struct {
        logic             mode;
        logic             bp;
        logic [7:0]       b;
        logic             eob;
        logic             pin;
        mbc_pkg::result_t want;
    } vec_row_t;

    logic                                   clk          = 1'b0;
    logic                                   rst_n        = 1'b0;
    logic                                   cfg_valid    = 1'b0;
    logic                                   cfg_ready;
    logic                                   relaxed_mode = 1'b0;
    logic                                   item_valid   = 1'b0;
    logic                                   item_ready;
    logic                                   byte_present = 1'b0;
    logic [7:0]                             body_byte    = 8'h00;
    logic                                   end_of_body  = 1'b0;
    logic                                   res_valid;
    logic                                   res_ready    = 1'b0;
    logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] newline_count;
    logic                                   space_before;
    logic                                   cr_before;
    logic                                   out_valid;
    logic [7:0]                             out_byte;
    logic                                   final_newline;
    logic                                   last_result;

    // Typed-in result travelling with the item on the bus
    logic             pin_valid = 1'b0;
    mbc_pkg::result_t pin_res   = '0;

    // Idle controls, set by the stimulus
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    logic        hold_req  = 1'b0;

    // Canonicalizer model state
    logic [mbc_pkg::NEWLINE_COUNT_BITS-1:0] crlf_backlog = '0;
    logic                                   wsp_pending  = 1'b0;
    logic                                   cr_waiting   = 1'b0;
    logic                                   body_started = 1'b0;
    logic                                   relaxed_sel  = 1'b0;

    mbc_pkg::result_t canon_expected_q[$];
    vec_row_t         vec_tab[$];
    int unsigned      mismatch_cnt = 0;
    int unsigned      quiet_cycles = 0;

    mail_body_canonicalizer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .relaxed_mode  (relaxed_mode),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .byte_present  (byte_present),
        .body_byte     (body_byte),
        .end_of_body   (end_of_body),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .newline_count (newline_count),
        .space_before  (space_before),
        .cr_before     (cr_before),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .final_newline (final_newline),
        .last_result   (last_result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Canonicalization model
    // ------------------------------------------------------------------

    // Flush held CRLFs and the pending space into the result
    function automatic void release_held(inout mbc_pkg::result_t r);
        r.newline_count = r.newline_count + crlf_backlog;
        r.space_before  = r.space_before | wsp_pending;
        crlf_backlog    = '0;
        wsp_pending     = 1'b0;
        body_started    = 1'b1;
    endfunction

    // Returns 1 when the item produces a result
    function automatic bit canon_predict(input logic bp, input logic [7:0] b,
                                         input logic eob, output mbc_pkg::result_t r);
        bit got;
        r   = '0;
        got = 1'b0;
        if (bp)
        begin
            if (cr_waiting && b == mbc_pkg::CH_LF)
            begin
                // CRLF: held back, saturating
                if (crlf_backlog != '1)
                    crlf_backlog = crlf_backlog + 1'b1;
                cr_waiting  = 1'b0;
                wsp_pending = 1'b0;
            end
            else if (relaxed_sel && (b == mbc_pkg::CH_SP || b == mbc_pkg::CH_TAB))
            begin
                if (cr_waiting)
                begin
                    release_held(r);
                    r.cr_before = 1'b1;
                    cr_waiting  = 1'b0;
                    got         = 1'b1;
                end
                wsp_pending = 1'b1;
            end
            else if (b == mbc_pkg::CH_CR)
            begin
                // a second CR makes the first one a lone CR
                if (cr_waiting)
                begin
                    release_held(r);
                    r.cr_before = 1'b1;
                    got         = 1'b1;
                end
                cr_waiting = 1'b1;
            end
            else
            begin
                release_held(r);
                r.cr_before = cr_waiting;
                r.out_valid = 1'b1;
                r.out_byte  = b;
                cr_waiting  = 1'b0;
                got         = 1'b1;
            end
        end
        if (eob)
        begin
            // a CR still held at the end goes out as content
            if (cr_waiting)
            begin
                release_held(r);
                r.out_valid = 1'b1;
                r.out_byte  = mbc_pkg::CH_CR;
                cr_waiting  = 1'b0;
            end
            r.final_newline = relaxed_sel ? body_started : 1'b1;
            r.last_result   = 1'b1;
            got             = 1'b1;
            crlf_backlog    = '0;
            wsp_pending     = 1'b0;
            cr_waiting      = 1'b0;
            body_started    = 1'b0;
        end
        return got;
    endfunction

    function automatic string fmt_res(input mbc_pkg::result_t r);
        return $sformatf("crlf=%0d sp=%0b cr=%0b byte=%0b/%02h fin=%0b last=%0b",
                         r.newline_count, r.space_before, r.cr_before,
                         r.out_valid, r.out_byte, r.final_newline,
                         r.last_result);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: results checked first, then the new item predicted
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        mbc_pkg::result_t seen;
        mbc_pkg::result_t want;
        bit               has_res;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                seen.newline_count = newline_count;
                seen.space_before  = space_before;
                seen.cr_before     = cr_before;
                seen.out_valid     = out_valid;
                seen.out_byte      = out_byte;
                seen.final_newline = final_newline;
                seen.last_result   = last_result;
                if (canon_expected_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: unexpected result %s", $time, fmt_res(seen));
                end
                else
                begin
                    want = canon_expected_q.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $time, fmt_res(want), fmt_res(seen));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                relaxed_sel = relaxed_mode;
            if (item_valid && item_ready)
            begin
                has_res = canon_predict(byte_present, body_byte, end_of_body, want);
                if (pin_valid)
                    canon_expected_q.push_back(pin_res);
                else if (has_res)
                    canon_expected_q.push_back(want);
            end
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        bit          hold_done;
        int unsigned k;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        res_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_ready <= 1'b0;
                k = $urandom_range(1, 6);
                repeat (k) @(posedge clk);
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item and hold it until accepted; valid stays high after
    task automatic send_item(input logic bp, input logic [7:0] b, input logic eob,
                             input logic pin, input mbc_pkg::result_t want);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        byte_present <= bp;
        body_byte    <= b;
        end_of_body  <= eob;
        pin_valid    <= pin;
        pin_res      <= want;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_item(1'b1, b, 1'b0, 1'b0, '0);
    endtask

    // Wait until every result is back and in-flight items have drained
    task automatic settle();
        @(posedge clk);
        while (canon_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid    <= 1'b1;
        relaxed_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_vec(input logic m, input logic bp, input logic [7:0] b,
                                    input logic eob, input logic pin,
                                    input int nl, input logic sp, input logic cr,
                                    input logic ov, input logic [7:0] ob,
                                    input logic fn, input logic lr);
        vec_row_t row;
        row.mode               = m;
        row.bp                 = bp;
        row.b                  = b;
        row.eob                = eob;
        row.pin                = pin;
        row.want.newline_count = nl[mbc_pkg::NEWLINE_COUNT_BITS-1:0];
        row.want.space_before  = sp;
        row.want.cr_before     = cr;
        row.want.out_valid     = ov;
        row.want.out_byte      = ob;
        row.want.final_newline = fn;
        row.want.last_result   = lr;
        vec_tab.push_back(row);
    endfunction

    // Random body traffic: mostly well-formed lines, some noise
    task automatic send_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned k;
        logic [7:0]  b;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                feed_byte(8'($urandom_range(0, 255)));
                sent += 1;
            end
            else if (pick < 35)
            begin
                feed_byte(8'($urandom_range(8'h21, 8'h7E)));
                sent += 1;
            end
            else if (pick < 48)
            begin
                feed_byte(mbc_pkg::CH_CR);
                feed_byte(mbc_pkg::CH_LF);
                sent += 2;
            end
            else if (pick < 54)
            begin
                feed_byte(mbc_pkg::CH_CR);
                sent += 1;
            end
            else if (pick < 58)
            begin
                feed_byte(mbc_pkg::CH_LF);
                sent += 1;
            end
            else if (pick < 68)
            begin
                feed_byte(mbc_pkg::CH_SP);
                sent += 1;
            end
            else if (pick < 75)
            begin
                feed_byte(mbc_pkg::CH_TAB);
                sent += 1;
            end
            else if (pick < 80)
            begin
                // whitespace run
                k = $urandom_range(2, 5);
                repeat (k)
                    feed_byte($urandom_range(0, 1) ? mbc_pkg::CH_SP : mbc_pkg::CH_TAB);
                sent += k;
            end
            else if (pick < 84)
            begin
                // empty item, no effect on the block
                send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            end
            else if (pick < 89)
            begin
                // empty lines
                k = $urandom_range(2, 5);
                repeat (k)
                begin
                    feed_byte(mbc_pkg::CH_CR);
                    feed_byte(mbc_pkg::CH_LF);
                end
                sent += 2 * k;
            end
            else if (pick < 93)
            begin
                // trailing whitespace on a line
                feed_byte(mbc_pkg::CH_SP);
                feed_byte(mbc_pkg::CH_TAB);
                feed_byte(mbc_pkg::CH_CR);
                feed_byte(mbc_pkg::CH_LF);
                sent += 4;
            end
            else if (pick < 97)
            begin
                // end of body, maybe carrying a last byte
                k = $urandom_range(0, 3);
                b = (k == 0) ? mbc_pkg::CH_CR : (k == 1) ? mbc_pkg::CH_SP :
                    (k == 2) ? mbc_pkg::CH_LF : 8'($urandom_range(0, 255));
                send_item(1'($urandom_range(0, 1)), b, 1'b1, 1'b0, '0);
                sent += 1;
            end
            else
            begin
                // CR left hanging at the end
                feed_byte(mbc_pkg::CH_CR);
                send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                sent += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned p;
        int unsigned k;
        logic        mode_now;
        logic        m;

        // Directed items, simple mode (reset value)
        //      mode bp   byte   eob  pin  crlf sp cr ov byte   fin  last
        add_vec(1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 0, 0, 0, 0, 8'h00, 1'b1, 1'b1);
        add_vec(1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 0, 0, 0, 1, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, 8'hFF, 1'b0, 1'b1, 0, 0, 0, 1, 8'hFF, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, mbc_pkg::CH_LF, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b0, 8'h5A, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, 8'h41, 1'b0, 1'b1, 1, 0, 0, 1, 8'h41, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, mbc_pkg::CH_TAB, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b0, 1'b0, 8'hA5, 1'b1, 1'b1, 0, 0, 0, 1, mbc_pkg::CH_CR, 1'b1, 1'b1);
        // relaxed mode
        add_vec(1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 0, 0, 0, 0, 8'h00, 1'b0, 1'b1);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_SP, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_TAB, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, 8'h61, 1'b0, 1'b1, 0, 1, 0, 1, 8'h61, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_SP, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_LF, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_LF, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_SP, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, 8'h62, 1'b1, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_CR, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_LF, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b1, mbc_pkg::CH_SP, 1'b0, 1'b0, 0, 0, 0, 0, 8'h00, 1'b0, 1'b0);
        add_vec(1'b1, 1'b0, 8'h3C, 1'b1, 1'b1, 0, 0, 0, 0, 8'h00, 1'b0, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        mode_now  = 1'b0;
        gap_pct   = 10;
        stall_pct = 10;

        // Directed table
        foreach (vec_tab[i])
        begin
            if (vec_tab[i].mode != mode_now)
            begin
                item_valid <= 1'b0;
                settle();
                write_mode(vec_tab[i].mode);
                mode_now = vec_tab[i].mode;
            end
            send_item(vec_tab[i].bp, vec_tab[i].b, vec_tab[i].eob,
                      vec_tab[i].pin, vec_tab[i].want);
        end

        // Random phases, mode switched between them
        for (p = 0; p < RAND_PHASES; p++)
        begin
            // in relaxed mode leave a space pending across the switch
            if (mode_now)
                feed_byte(mbc_pkg::CH_SP);
            item_valid <= 1'b0;
            settle();
            m = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            write_mode(m);
            mode_now = m;
            if (p == RAND_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                k         = $urandom_range(0, 2);
                gap_pct   = k * 15;
                k         = $urandom_range(0, 2);
                stall_pct = k * 15;
            end
            if (p == PRESSURE_PHASE)
            begin
                gap_pct = 0;
                hold_req <= 1'b1;
            end
            send_random(PHASE_ITEMS);
        end

        // Build a short CRLF backlog, release it and close the body
        feed_byte(8'h53);
        repeat (TAIL_LINES)
        begin
            feed_byte(mbc_pkg::CH_CR);
            feed_byte(mbc_pkg::CH_LF);
        end
        feed_byte(8'h54);
        send_item(1'b0, 8'h00, 1'b1, 1'b0, '0);
        item_valid <= 1'b0;
        settle();

        if (mismatch_cnt == 0 && canon_expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
